// ----- hdl/depa_pkg.sv -----
package depa_pkg;

  localparam int DEF_POOL_DEPTH = 1024;

  localparam int CNT_W = 11;
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] RST_ELEMENTS = 11'd1024;
  localparam logic [CNT_W-1:0] RST_LEFT_PRE = 11'd0;
  localparam logic [CNT_W-1:0] RST_RIGHT_PRE = 11'd0;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PRE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PRE = 2'd2;

  typedef enum logic [2:0] {
    CMD_ALLOC_LEFT  = 3'd0,
    CMD_ALLOC_RIGHT = 3'd1,
    CMD_FREE_LEFT   = 3'd2,
    CMD_FREE_RIGHT  = 3'd3,
    CMD_FREE_AUTO   = 3'd4,
    CMD_INIT        = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_BAD_FREE   = 2'd2,
    ST_BAD_CONFIG = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

endpackage

// ----- hdl/depa_ram.sv -----
module depa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/depa_ctrl.sv -----
module depa_ctrl
  import depa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t ctl
);

  fsm_t state;
  fsm_t state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.commit  = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid || out_ready) begin
          ctl.commit = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
    out_valid_next = ctl.commit | (out_valid & ~out_ready);
  end

endmodule

// ----- hdl/depa_dp.sv -----
module depa_dp
  import depa_pkg::*;
#(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             ctl,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic [2:0]           command,
  input  logic [IDX_W-1:0]     slot_index,
  output logic [IDX_W-1:0]     granted_index,
  output logic [1:0]           status
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(POOL_DEPTH);

  logic [CNT_W-1:0] elements_in_use;
  logic [CNT_W-1:0] left_preallocated;
  logic [CNT_W-1:0] right_preallocated;

  logic [CNT_W-1:0] left_stack_count, left_stack_count_next;
  logic [CNT_W-1:0] right_stack_base, right_stack_base_next;
  logic [CNT_W-1:0] left_bump_mark, left_bump_mark_next;
  logic [CNT_W-1:0] right_bump_mark, right_bump_mark_next;
  logic [CNT_W-1:0] latched_elements, latched_elements_next;

  cmd_t             cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic             rd_ok;

  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_rdata;
  logic [IDX_W-1:0] pop_data;

  logic [IDX_W-1:0] granted_next;
  status_t          status_next;
  logic             left_bad;
  logic             right_bad;
  logic             do_left;
  logic [CNT_W:0]   pre_sum;
  logic [CNT_W-1:0] rbm_dec;
  logic [CNT_W-1:0] rsb_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      elements_in_use    <= RST_ELEMENTS;
      left_preallocated  <= RST_LEFT_PRE;
      right_preallocated <= RST_RIGHT_PRE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEMENTS:  elements_in_use <= cfg_data;
        REG_LEFT_PRE:  left_preallocated <= cfg_data;
        REG_RIGHT_PRE: right_preallocated <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_stack_count <= '0;
      right_stack_base <= RST_ELEMENTS;
      left_bump_mark   <= RST_LEFT_PRE;
      right_bump_mark  <= RST_ELEMENTS - RST_RIGHT_PRE;
      latched_elements <= RST_ELEMENTS;
    end else if (ctl.commit) begin
      left_stack_count <= left_stack_count_next;
      right_stack_base <= right_stack_base_next;
      left_bump_mark   <= left_bump_mark_next;
      right_bump_mark  <= right_bump_mark_next;
      latched_elements <= latched_elements_next;
    end
  end

  // The read address is formed from the request itself, so the memory
  // word is registered at capture and ready when the pointers are updated at commit.
  always_comb begin
    rd_ptr = (cmd_t'(command) == CMD_ALLOC_RIGHT) ? right_stack_base
                                                  : left_stack_count - 11'd1;
    mem_re = ctl.capture && (cmd_t'(command) == CMD_ALLOC_LEFT ||
                             cmd_t'(command) == CMD_ALLOC_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd_t'(command);
      idx_q <= slot_index;
      rd_ok <= 32'(rd_ptr) < DEPTH_W;
    end
  end

  depa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(POOL_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(wr_ptr)),
    .wdata(idx_q),
    .re   (mem_re),
    .raddr(AW'(rd_ptr)),
    .rdata(mem_rdata)
  );

  assign pop_data = rd_ok ? mem_rdata : '0;

  always_comb begin
    left_stack_count_next = left_stack_count;
    right_stack_base_next = right_stack_base;
    left_bump_mark_next   = left_bump_mark;
    right_bump_mark_next  = right_bump_mark;
    latched_elements_next = latched_elements;
    granted_next = '0;
    status_next  = ST_OK;
    mem_we = 1'b0;
    wr_ptr = left_stack_count;

    rbm_dec = right_bump_mark - 11'd1;
    rsb_dec = right_stack_base - 11'd1;
    pre_sum = {1'b0, left_preallocated} + {1'b0, right_preallocated};
    left_bad = ({1'b0, idx_q} >= left_bump_mark) ||
               (left_stack_count >= right_stack_base);
    right_bad = ({1'b0, idx_q} < right_bump_mark) ||
                ({1'b0, idx_q} >= latched_elements) ||
                (right_stack_base <= left_stack_count);
    do_left = (cmd_q == CMD_FREE_LEFT) ||
              (cmd_q == CMD_FREE_AUTO && {1'b0, idx_q} < left_bump_mark);

    case (cmd_q) inside
      CMD_ALLOC_LEFT: begin
        if (left_stack_count != '0) begin
          left_stack_count_next = left_stack_count - 11'd1;
          granted_next = pop_data;
        end else if (left_bump_mark < right_bump_mark) begin
          granted_next = left_bump_mark[IDX_W-1:0];
          left_bump_mark_next = left_bump_mark + 11'd1;
        end else begin
          status_next = ST_EXHAUSTED;
        end
      end
      CMD_ALLOC_RIGHT: begin
        if (right_stack_base < latched_elements) begin
          granted_next = pop_data;
          right_stack_base_next = right_stack_base + 11'd1;
        end else if (left_bump_mark < right_bump_mark) begin
          right_bump_mark_next = rbm_dec;
          granted_next = rbm_dec[IDX_W-1:0];
        end else begin
          status_next = ST_EXHAUSTED;
        end
      end
      CMD_FREE_LEFT, CMD_FREE_RIGHT, CMD_FREE_AUTO: begin
        if (do_left) begin
          if (left_bad) begin
            status_next = ST_BAD_FREE;
          end else begin
            wr_ptr = left_stack_count;
            mem_we = ctl.commit && (32'(left_stack_count) < DEPTH_W);
            left_stack_count_next = left_stack_count + 11'd1;
          end
        end else begin
          if (right_bad) begin
            status_next = ST_BAD_FREE;
          end else begin
            wr_ptr = rsb_dec;
            mem_we = ctl.commit && (32'(rsb_dec) < DEPTH_W);
            right_stack_base_next = rsb_dec;
          end
        end
      end
      CMD_INIT: begin
        if (elements_in_use == '0 || 32'(elements_in_use) > DEPTH_W ||
            pre_sum > {1'b0, elements_in_use}) begin
          status_next = ST_BAD_CONFIG;
        end else begin
          left_stack_count_next = '0;
          right_stack_base_next = elements_in_use;
          left_bump_mark_next   = left_preallocated;
          right_bump_mark_next  = elements_in_use - right_preallocated;
          latched_elements_next = elements_in_use;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      granted_index <= granted_next;
      status        <= status_next;
    end
  end

endmodule

// ----- hdl/double_ended_pool_allocator.sv -----
// Slot pool allocator that hands out indices from both ends of a pool of
// elements_in_use slots, with a left and a right free stack sharing one
// memory of POOL_DEPTH words. The idle state accepts a request and reads
// the shared free stack memory; the execute state, which waits while an
// earlier result has not been taken, updates the pointers, writes a freed
// slot and loads the result register. A new request is accepted once the
// previous one has reached the result register, even while that result
// still waits to be taken. Configuration registers take effect only at
// the next init request. No clearing pass runs after reset.
module double_ended_pool_allocator
  import depa_pkg::*;
#(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           command,
  input  logic [IDX_W-1:0]     slot_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     granted_index,
  output logic [1:0]           status
);

  ctl_cmd_t ctl;

  depa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl)
  );

  depa_dp #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .slot_index   (slot_index),
    .granted_index(granted_index),
    .status       (status)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_error_grants_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_index == '0)
    else $error("nonzero index returned with an error status");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an executing request");

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import depa_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 91;

  typedef struct {
    logic [2:0]       cmd;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] granted;
    status_t          status;
  } pool_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           command = '0;
  logic [IDX_W-1:0]     slot_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     granted_index;
  logic [1:0]           status;

  int idle_pct = 21;
  int errors = 0;
  int cycles = 0;

  pool_result_t pending_grants[$];
  logic [IDX_W-1:0] held_slots[$];

  logic [CNT_W-1:0] cfg_elements = RST_ELEMENTS;
  logic [CNT_W-1:0] cfg_left_pre = RST_LEFT_PRE;
  logic [CNT_W-1:0] cfg_right_pre = RST_RIGHT_PRE;
  logic [CNT_W-1:0] left_depth = '0;
  logic [CNT_W-1:0] right_floor = RST_ELEMENTS;
  logic [CNT_W-1:0] low_mark = RST_LEFT_PRE;
  logic [CNT_W-1:0] high_mark = RST_ELEMENTS;
  logic [CNT_W-1:0] pool_size = RST_ELEMENTS;
  logic [IDX_W-1:0] slot_mem [DEF_POOL_DEPTH];

  double_ended_pool_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .granted_index(granted_index),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic status_t push_left_stack(logic [IDX_W-1:0] slot);
    if (slot >= low_mark || left_depth >= right_floor) begin
      return ST_BAD_FREE;
    end
    slot_mem[left_depth] = slot;
    left_depth++;
    return ST_OK;
  endfunction

  function automatic status_t push_right_stack(logic [IDX_W-1:0] slot);
    if (slot < high_mark || slot >= pool_size || right_floor <= left_depth) begin
      return ST_BAD_FREE;
    end
    right_floor--;
    slot_mem[right_floor] = slot;
    return ST_OK;
  endfunction

  function automatic pool_result_t pool_step(logic [2:0] cmd, logic [IDX_W-1:0] slot);
    pool_result_t r;
    r.cmd = cmd;
    r.slot = slot;
    r.granted = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ALLOC_LEFT: begin
        if (left_depth != 0) begin
          left_depth--;
          r.granted = slot_mem[left_depth];
        end else if (low_mark < high_mark) begin
          r.granted = low_mark[IDX_W-1:0];
          low_mark++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      CMD_ALLOC_RIGHT: begin
        if (right_floor < pool_size) begin
          r.granted = slot_mem[right_floor];
          right_floor++;
        end else if (low_mark < high_mark) begin
          high_mark--;
          r.granted = high_mark[IDX_W-1:0];
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      CMD_FREE_LEFT: r.status = push_left_stack(slot);
      CMD_FREE_RIGHT: r.status = push_right_stack(slot);
      CMD_FREE_AUTO: begin
        if (slot < low_mark) begin
          r.status = push_left_stack(slot);
        end else begin
          r.status = push_right_stack(slot);
        end
      end
      CMD_INIT: begin
        if (cfg_elements == 0 || cfg_elements > DEF_POOL_DEPTH ||
            int'(cfg_left_pre) + int'(cfg_right_pre) > int'(cfg_elements)) begin
          r.status = ST_BAD_CONFIG;
        end else begin
          left_depth = '0;
          right_floor = cfg_elements;
          low_mark = cfg_left_pre;
          high_mark = cfg_elements - cfg_right_pre;
          pool_size = cfg_elements;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_error(string what);
    errors++;
    if (errors <= 10) begin
      $display("%s", what);
    end
  endtask

  always @(posedge clk) begin
    pool_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        note_error($sformatf("unexpected result: grant %0d status %0d",
                             granted_index, status));
      end else begin
        e = pending_grants.pop_front();
        if (granted_index !== e.granted || status !== e.status) begin
          note_error($sformatf({"command %0d slot %0d: expected grant %0d status %0d,",
                                " got grant %0d status %0d"}, e.cmd, e.slot,
                               e.granted, e.status, granted_index, status));
        end
      end
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [IDX_W-1:0] slot);
    pool_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    slot_index = slot;
    do @(posedge clk); while (!in_ready);
    r = pool_step(cmd, slot);
    pending_grants.push_back(r);
    if ((cmd == CMD_ALLOC_LEFT || cmd == CMD_ALLOC_RIGHT) && r.status == ST_OK) begin
      held_slots.push_back(r.granted);
    end
    if (cmd == CMD_INIT && r.status == ST_OK) begin
      held_slots.delete();
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ELEMENTS: cfg_elements = data;
      REG_LEFT_PRE: cfg_left_pre = data;
      REG_RIGHT_PRE: cfg_right_pre = data;
      default: ;
    endcase
  endtask

  task automatic configure_pool(int elements, int left_pre, int right_pre);
    wait_for_results();
    write_register(REG_ELEMENTS, CNT_W'(elements));
    write_register(REG_LEFT_PRE, CNT_W'(left_pre));
    write_register(REG_RIGHT_PRE, CNT_W'(right_pre));
    send_request(CMD_INIT, '0);
  endtask

  task automatic test_reset_state();
    send_request(CMD_ALLOC_RIGHT, 10'd0);
    send_request(CMD_ALLOC_LEFT, 10'd1023);
    send_request(CMD_FREE_LEFT, 10'd1023);
    send_request(CMD_FREE_RIGHT, 10'd0);
    send_request(CMD_FREE_RIGHT, 10'd1023);
    send_request(CMD_FREE_LEFT, 10'd0);
    send_request(CMD_ALLOC_RIGHT, 10'd0);
    send_request(CMD_ALLOC_LEFT, 10'd0);
    send_request(CMD_FREE_AUTO, 10'd1023);
    send_request(CMD_FREE_AUTO, 10'd0);
    send_request(CMD_SPARE_6, 10'd1023);
    send_request(CMD_SPARE_7, 10'd0);
  endtask

  task automatic test_bad_config();
    configure_pool(0, 0, 0);
    configure_pool(2047, 2047, 2047);
    configure_pool(1025, 0, 0);
    wait_for_results();
    write_register(REG_SPARE, 11'd2047);
    configure_pool(16, 10, 7);
    configure_pool(16, 9, 7);
    send_request(CMD_ALLOC_LEFT, 10'd0);
    send_request(CMD_ALLOC_RIGHT, 10'd0);
    send_request(CMD_FREE_AUTO, 10'd8);
    send_request(CMD_FREE_RIGHT, 10'd15);
    send_request(CMD_FREE_RIGHT, 10'd16);
    send_request(CMD_ALLOC_LEFT, 10'd0);
    send_request(CMD_ALLOC_RIGHT, 10'd0);
  endtask

  // With a single slot, a second free of the same slot finds the stacks touching.
  task automatic test_full_stacks();
    configure_pool(1, 0, 0);
    send_request(CMD_ALLOC_LEFT, 10'd0);
    send_request(CMD_ALLOC_LEFT, 10'd0);
    send_request(CMD_FREE_LEFT, 10'd0);
    send_request(CMD_FREE_LEFT, 10'd0);
    configure_pool(1, 0, 1);
    send_request(CMD_FREE_RIGHT, 10'd0);
    send_request(CMD_FREE_RIGHT, 10'd0);
    send_request(CMD_ALLOC_RIGHT, 10'd0);
  endtask

  task automatic test_random_traffic();
    int elements;
    int left_pre;
    int right_pre;
    int roll;
    int k;
    logic [2:0] cmd;
    logic [IDX_W-1:0] slot;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin elements = 1024; left_pre = 0; right_pre = 0; end
        1: begin elements = 1; left_pre = 0; right_pre = 0; end
        2: begin elements = 1024; left_pre = 512; right_pre = 512; end
        3: begin elements = 1024; left_pre = 0; right_pre = 1024; end
        4: begin elements = 1024; left_pre = 1024; right_pre = 0; end
        5: begin elements = 3; left_pre = 1; right_pre = 1; end
        default: begin
          elements = $urandom_range(2, 48);
          left_pre = $urandom_range(0, elements / 3);
          right_pre = $urandom_range(0, elements / 3);
        end
      endcase
      configure_pool(elements, left_pre, right_pre);
      idle_pct = (p == 6) ? 0 : 21;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == PHASE_ITEMS / 2) begin
          wait_for_results();
        end
        roll = $urandom_range(0, 99);
        slot = IDX_W'($urandom);
        if (roll < 30) begin
          cmd = CMD_ALLOC_LEFT;
        end else if (roll < 55) begin
          cmd = CMD_ALLOC_RIGHT;
        end else if (roll < 85 && held_slots.size() != 0) begin
          k = $urandom_range(0, held_slots.size() - 1);
          slot = held_slots[k];
          held_slots.delete(k);
          roll = $urandom_range(0, 99);
          cmd = (roll < 70) ? CMD_FREE_AUTO : (roll < 85) ? CMD_FREE_LEFT : CMD_FREE_RIGHT;
        end else if (roll < 96) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_FREE_LEFT;
            1: cmd = CMD_FREE_RIGHT;
            default: cmd = CMD_FREE_AUTO;
          endcase
        end else if (roll < 98) begin
          cmd = CMD_INIT;
        end else begin
          cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        send_request(cmd, slot);
      end
    end
    idle_pct = 21;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_bad_config();
    test_full_stacks();
    test_random_traffic();
    wait_for_results();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
